[design/ief_pkg.sv]
package ief_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 64;

    localparam logic [7:0] THRESHOLD_RESET = 8'd5;
    localparam logic [7:0] COUNT_MAX       = 8'd255;
    localparam logic [3:0] IP_V4           = 4'd4;
    localparam logic [7:0] PROTO_ICMP      = 8'd1;
    localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;

    localparam logic [1:0] VERDICT_NONE  = 2'd0;
    localparam logic [1:0] VERDICT_NEW   = 2'd1;
    localparam logic [1:0] VERDICT_EXIST = 2'd2;
    localparam logic [1:0] VERDICT_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]  ip_version;
        logic [7:0]  ip_protocol;
        logic [7:0]  icmp_type;
        logic [31:0] src_addr;
        logic [31:0] now_second;
    } pkt_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] hit_count;
        logic       alarm;
    } result_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [7:0]  count;
        logic [31:0] second;
    } entry_t;

endpackage

[design/icmp_echo_flood_detector.sv]
// channel   | signals                 | handshake
// ----------+-------------------------+-----------------------------------
// packet    | pkt (pkt_t)             | taken when start high, busy low
// result    | result (result_t)       | valid for one cycle while done high
// config    | cfg_data (threshold)    | written when cfg_we high
//
// a filtered packet, or any packet after the alarm, gives its result in the cycle
// after it is taken; a counted packet first scans the source table through its
// single registered read port, then takes the update step before its result.
// reset clears the valid bits, the alarm and the sequencer, and loads the
// threshold with 5. the receiver cannot stall; busy holds off new packets.
module icmp_echo_flood_detector #(
    parameter int unsigned TABLE_ENTRIES = ief_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ief_pkg::pkt_t     pkt,
    output logic              done,
    output ief_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data
);
    import ief_pkg::*;

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t                   state_reg;
    pkt_t                     pkt_reg;
    result_t                  result_reg;
    logic                     done_reg;
    logic                     alarm_reg;
    logic [7:0]               threshold_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic                     issue_reg;
    logic                     cmp_vld_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     hit_found_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [7:0]               hit_cnt_reg;
    logic [31:0]              hit_sec_reg;
    logic                     spare_found_reg;
    logic [IDX_W-1:0]         spare_idx_reg;

    entry_t                   rd_entry;
    entry_t                   wr_entry;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic                     counted;
    logic                     cmp_valid_bit;
    logic                     cmp_match;
    logic [7:0]               upd_count;
    logic [1:0]               upd_verdict;
    logic                     upd_alarm;

    assign counted = (pkt.ip_version == IP_V4) && (pkt.ip_protocol == PROTO_ICMP)
                     && (pkt.icmp_type == ICMP_ECHO_REQ) && !alarm_reg;

    assign cmp_valid_bit = valid_reg[cmp_idx_reg];
    assign cmp_match     = cmp_valid_bit && (rd_entry.addr == pkt_reg.src_addr);

    // update step
    always_comb
    begin
        wr_en       = 1'b0;
        wr_idx      = hit_idx_reg;
        wr_entry    = '{addr: pkt_reg.src_addr, count: 8'd1, second: pkt_reg.now_second};
        upd_count   = 8'd0;
        upd_verdict = VERDICT_FULL;
        if (hit_found_reg)
        begin
            if (hit_sec_reg != pkt_reg.now_second)
            begin
                upd_count = 8'd1;
            end
            else if (hit_cnt_reg != COUNT_MAX)
            begin
                upd_count = hit_cnt_reg + 8'd1;
            end
            else
            begin
                upd_count = hit_cnt_reg;
            end
            wr_entry.count = upd_count;
            upd_verdict    = VERDICT_EXIST;
            wr_en          = (state_reg == ST_UPDATE);
        end
        else if (spare_found_reg)
        begin
            upd_count   = 8'd1;
            upd_verdict = VERDICT_NEW;
            wr_idx      = spare_idx_reg;
            wr_en       = (state_reg == ST_UPDATE);
        end
        upd_alarm = alarm_reg || ((upd_verdict != VERDICT_FULL) && (upd_count > threshold_reg));
    end

    ief_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .raddr (scan_idx_reg),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            alarm_reg       <= 1'b0;
            threshold_reg   <= THRESHOLD_RESET;
            valid_reg       <= '0;
            scan_idx_reg    <= '0;
            issue_reg       <= 1'b0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            hit_found_reg   <= 1'b0;
            spare_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= start && !counted;
                    if (start)
                    begin
                        pkt_reg <= pkt;
                        if (counted)
                        begin
                            state_reg       <= ST_SCAN;
                            scan_idx_reg    <= '0;
                            issue_reg       <= 1'b1;
                            cmp_vld_reg     <= 1'b0;
                            hit_found_reg   <= 1'b0;
                            spare_found_reg <= 1'b0;
                        end
                        else
                        begin
                            result_reg <= '{verdict: VERDICT_NONE, hit_count: 8'd0,
                                            alarm: alarm_reg};
                        end
                    end
                end
                ST_SCAN:
                begin
                    done_reg <= 1'b0;
                    // the compare follows the read issue in the next cycle, on the registered read data
                    cmp_vld_reg <= issue_reg;
                    cmp_idx_reg <= scan_idx_reg;
                    if (issue_reg)
                    begin
                        if (scan_idx_reg == LAST_IDX)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                    if (cmp_vld_reg)
                    begin
                        if (cmp_match && !hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= cmp_idx_reg;
                            hit_cnt_reg   <= rd_entry.count;
                            hit_sec_reg   <= rd_entry.second;
                        end
                        if (!cmp_valid_bit && !spare_found_reg)
                        begin
                            spare_found_reg <= 1'b1;
                            spare_idx_reg   <= cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    if (!hit_found_reg && spare_found_reg)
                    begin
                        valid_reg[spare_idx_reg] <= 1'b1;
                    end
                    alarm_reg  <= upd_alarm;
                    result_reg <= '{verdict: upd_verdict, hit_count: upd_count,
                                    alarm: upd_alarm};
                    done_reg   <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_update_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> done)
        else $error("update step gave no result");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.verdict == VERDICT_FULL || result.verdict == VERDICT_NONE))
        |-> (result.hit_count == 8'd0))
        else $error("nonzero count on untracked or filtered result");

    a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_reg |=> alarm_reg)
        else $error("alarm cleared");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && alarm_reg) |=> (done && result.verdict == VERDICT_NONE
                                          && result.alarm))
        else $error("packet counted after alarm");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_UPDATE) && !alarm_reg)
        else $error("table written outside update step");

endmodule

[design/ief_table.sv]
module ief_table #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned IDX_W   = 6
) (
    input  logic               clk,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  ief_pkg::entry_t    wdata,
    input  logic [IDX_W-1:0]   raddr,
    output ief_pkg::entry_t    rdata
);
    import ief_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
